// ===== rtl/tce_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the tiny CPU execute unit.
// No dependencies; imported by the front, queue, back and top-level modules.
package tce_pkg;

	// Machine dimensions
	localparam int TCE_NUM_REGS    = 8;
	localparam int TCE_REG_IDX_W   = 3;
	localparam int TCE_DATA_W      = 8;
	localparam int TCE_QUEUE_DEPTH = 2;

	// Register write index that selects the program counter
	localparam logic [3:0] TCE_PC_INDEX = 4'd8;

	// Item kind carried on tuser
	typedef enum logic [1:0] {
		KIND_INSN  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_REGWR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// Major opcodes, instruction bits [19:17]
	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_ADDI   = 3'd1,
		OP_MUL    = 3'd2,
		OP_INV    = 3'd3,
		OP_BRANCH = 3'd4,
		OP_LOAD   = 3'd5,
		OP_STORE  = 3'd6,
		OP_HALT   = 3'd7
	} op_t;

	// Branch subcodes held in the destination field
	localparam logic [2:0] BR_EQ = 3'd0;
	localparam logic [2:0] BR_NE = 3'd1;
	localparam logic [2:0] BR_LT = 3'd2;

	// Decoded item handed from front to back
	typedef struct packed {
		kind_t                     kind;
		op_t                       op;
		logic [TCE_REG_IDX_W-1:0]  dest;
		logic [TCE_REG_IDX_W-1:0]  src;
		logic [TCE_REG_IDX_W-1:0]  tgt;
		logic [TCE_DATA_W-1:0]     imm;
		logic [TCE_DATA_W-1:0]     data;      // load data or register write value
		logic                      wr_gpr;    // register write to a general register
		logic                      wr_pc;     // register write to the PC
	} item_t;

endpackage

// ===== rtl/tce_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input transactions, splits the instruction word and classifies the item.
// Depends on tce_pkg.
module tce_front
	import tce_pkg::*;
(
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // instruction[19:0], load_data[27:20], reg_index[31:28],
	                               // reg_value[39:32]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        push_valid,
	input  logic        push_ready,
	output item_t       push_item
);

	logic [19:0] insn;
	logic [7:0]  load_data;
	logic [3:0]  reg_index;
	logic [7:0]  reg_value;
	kind_t       kind;

	assign insn      = s_tdata[19:0];
	assign load_data = s_tdata[27:20];
	assign reg_index = s_tdata[31:28];
	assign reg_value = s_tdata[39:32];
	assign kind      = kind_t'(s_tuser);

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;

	// Field split and classification
	always_comb begin
		push_item.kind   = kind;
		push_item.op     = op_t'(insn[19:17]);
		// a register write carries its target register in the destination field
		push_item.dest   = (kind == KIND_REGWR) ? reg_index[2:0] : insn[16:14];
		push_item.src    = insn[13:11];
		push_item.tgt    = insn[10:8];
		push_item.imm    = insn[7:0];
		push_item.data   = (kind == KIND_DONE) ? load_data : reg_value;
		push_item.wr_gpr = (kind == KIND_REGWR) && !reg_index[3];
		push_item.wr_pc  = (kind == KIND_REGWR) && (reg_index == TCE_PC_INDEX);
	end

endmodule

// ===== rtl/tce_queue.sv =====
`timescale 1ns / 1ps
// Short queue of decoded items between front and back end.
// Depends on tce_pkg.
module tce_queue
	import tce_pkg::*;
#(
	parameter int DEPTH = TCE_QUEUE_DEPTH   // 2 or more
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop,
	output item_t pop_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	item_t            entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// Entry storage, payload only
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== rtl/tce_back.sv =====
`timescale 1ns / 1ps
// Back end: architectural state, instruction execution and the output register.
// Depends on tce_pkg.
module tce_back
	import tce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop,
	input  item_t       pop_item,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // pc[7:0], halted[8], waiting[9], mem_valid[10],
	                               // mem_is_store[11], mem_address[19:12],
	                               // store_data[27:20], reg_written[28],
	                               // written_index[31:29], written_value[39:32]
);

	// Architectural state
	logic [TCE_DATA_W-1:0]    rf_q [TCE_NUM_REGS];
	logic [TCE_DATA_W-1:0]    pc_q;
	logic                     halt_q;
	logic                     wait_q;
	logic                     pend_load_q;
	logic [TCE_REG_IDX_W-1:0] pend_dest_q;

	// Output register
	logic        out_valid_q;
	logic [39:0] out_data_q;

	// Next-state values
	logic [TCE_DATA_W-1:0]    pc_d;
	logic                     halt_d;
	logic                     wait_d;
	logic                     pend_load_d;
	logic [TCE_REG_IDX_W-1:0] pend_dest_d;

	// Result fields
	logic                     mem_valid;
	logic                     mem_is_store;
	logic [TCE_DATA_W-1:0]    mem_address;
	logic [TCE_DATA_W-1:0]    store_data;
	logic                     reg_written;
	logic [TCE_REG_IDX_W-1:0] written_index;
	logic [TCE_DATA_W-1:0]    written_value;

	logic [TCE_DATA_W-1:0]    rs;
	logic [TCE_DATA_W-1:0]    rt;
	logic                     taken;

	// Execute when an item is queued and the output slot is free or draining
	assign pop      = pop_valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign rs = rf_q[pop_item.src];
	assign rt = rf_q[pop_item.tgt];

	// Execute
	always_comb begin
		pc_d          = pc_q;
		halt_d        = halt_q;
		wait_d        = wait_q;
		pend_load_d   = pend_load_q;
		pend_dest_d   = pend_dest_q;
		mem_valid     = 1'b0;
		mem_is_store  = 1'b0;
		mem_address   = '0;
		store_data    = '0;
		reg_written   = 1'b0;
		written_index = '0;
		written_value = '0;
		taken         = 1'b0;
		unique case (pop_item.kind)
			KIND_INSN: begin
				if (!halt_q && !wait_q) begin
					pc_d = pc_q + 1'b1;
					unique case (pop_item.op)
						OP_ADD: begin
							reg_written   = 1'b1;
							written_value = rs + rt;
						end
						OP_ADDI: begin
							reg_written   = 1'b1;
							written_value = rs + pop_item.imm;
						end
						OP_MUL: begin
							reg_written   = 1'b1;
							written_value = rs[7:4] * rs[3:0];
						end
						OP_INV: begin
							reg_written   = 1'b1;
							written_value = ~rs;
						end
						OP_BRANCH: begin
							unique case (pop_item.dest)
								BR_EQ:   taken = (rs == rt);
								BR_NE:   taken = (rs != rt);
								BR_LT:   taken = ($signed(rs) < $signed(rt));
								default: taken = 1'b0;
							endcase
							if (taken)
								pc_d = pop_item.imm;
						end
						OP_LOAD: begin
							mem_valid   = 1'b1;
							mem_address = rt;
							wait_d      = 1'b1;
							pend_load_d = 1'b1;
							pend_dest_d = pop_item.dest;
							pc_d        = pc_q;
						end
						OP_STORE: begin
							mem_valid    = 1'b1;
							mem_is_store = 1'b1;
							mem_address  = rt;
							store_data   = rs;
							wait_d       = 1'b1;
							pend_load_d  = 1'b0;
							pc_d         = pc_q;
						end
						OP_HALT: begin
							halt_d = 1'b1;
						end
						default: ;
					endcase
					if (reg_written)
						written_index = pop_item.dest;
				end
			end
			KIND_DONE: begin
				if (wait_q) begin
					if (pend_load_q) begin
						reg_written   = 1'b1;
						written_index = pend_dest_q;
						written_value = pop_item.data;
					end
					wait_d      = 1'b0;
					pend_load_d = 1'b0;
					pc_d        = pc_q + 1'b1;
				end
			end
			KIND_REGWR: begin
				if (pop_item.wr_gpr) begin
					reg_written   = 1'b1;
					written_index = pop_item.dest;
					written_value = pop_item.data;
				end else if (pop_item.wr_pc) begin
					pc_d        = pop_item.data;
					halt_d      = 1'b0;
					wait_d      = 1'b0;
					pend_load_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// State and output register update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TCE_NUM_REGS; i++)
				rf_q[i] <= '0;
			pc_q        <= '0;
			halt_q      <= 1'b0;
			wait_q      <= 1'b0;
			pend_load_q <= 1'b0;
			pend_dest_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (reg_written)
					rf_q[written_index] <= written_value;
				pc_q        <= pc_d;
				halt_q      <= halt_d;
				wait_q      <= wait_d;
				pend_load_q <= pend_load_d;
				pend_dest_q <= pend_dest_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (pop)
			out_data_q <= {written_value, written_index, reg_written, store_data,
			               mem_address, mem_is_store, mem_valid, wait_d, halt_d, pc_d};
	end

endmodule

// ===== rtl/tiny_cpu_execute_unit_core.sv =====
`timescale 1ns / 1ps
// Execute unit for an eight-register 8-bit machine with 20-bit instructions.
// Path: an input transaction is written into the queue, then executed into the output register on m_tdata.
// Throughput: one item per cycle while m_tready keeps the output register draining, set by the back end execute stage.
// Reset: arst_n clears registers, PC, flags, queue and output valid asynchronously.
// Depends on tce_pkg, tce_front, tce_queue and tce_back.
module tiny_cpu_execute_unit_core
	import tce_pkg::*;
#(
	parameter int QUEUE_DEPTH = TCE_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // instruction[19:0], load_data[27:20], reg_index[31:28],
	                               // reg_value[39:32]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // pc[7:0], halted[8], waiting[9], mem_valid[10],
	                               // mem_is_store[11], mem_address[19:12],
	                               // store_data[27:20], reg_written[28],
	                               // written_index[31:29], written_value[39:32]
);

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop;
	item_t pop_item;

	tce_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	tce_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	tce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_item  (pop_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tiny_cpu_execute_unit_core: stream driver, result monitor,
// and an in-bench predictor of PC, flags, memory requests and register writes.
// Depends on tce_pkg and the execute unit RTL only.
module tb;
	import tce_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_ITEMS = 650;
	localparam int REPORT_MAX   = 10;

	// One input item, packed top-down so {reg_value, reg_index, load_data, instruction} is tdata
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  reg_value;
		logic [3:0]  reg_index;
		logic [7:0]  load_data;
		logic [19:0] instruction;
	} cpu_item_t;

	// One result, laid out exactly as m_tdata
	typedef struct packed {
		logic [7:0] written_value;
		logic [2:0] written_index;
		logic       reg_written;
		logic [7:0] store_data;
		logic [7:0] mem_address;
		logic       mem_is_store;
		logic       mem_valid;
		logic       waiting;
		logic       halted;
		logic [7:0] pc;
	} status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = KIND_INSN;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	tiny_cpu_execute_unit_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock
	initial begin
		forever #4 clk = ~clk;
	end

	cpu_item_t item_q[$];
	status_t   status_q[$];
	cpu_item_t cur_item;

	int mismatches   = 0;
	int n_results    = 0;
	int n_accepted   = 0;
	int n_exec       = 0;
	int n_mem        = 0;
	int n_taken      = 0;
	int n_reg_writes = 0;

	// Predicted machine state
	logic [7:0] cpu_regs [TCE_NUM_REGS] = '{default: 8'h00};
	logic [7:0] cpu_pc        = 8'h00;
	logic       cpu_halted    = 1'b0;
	logic       cpu_waiting   = 1'b0;
	logic       cpu_pend_load = 1'b0;
	logic [2:0] cpu_pend_dest = 3'd0;

	// Generator's view of the flags, used only to shape stimulus
	logic gen_waiting = 1'b0;
	logic gen_halted  = 1'b0;
	int   gen_useful  = 0;

	// Apply one item to the predicted state and return the status it produces
	function automatic status_t exec_item(cpu_item_t it);
		status_t    r;
		op_t        op;
		logic [2:0] d, s, t;
		logic [7:0] imm, rs, rt, res;
		logic       wr, taken, adv;
		r = '0;
		case (it.kind)
			KIND_INSN: begin
				if (!cpu_halted && !cpu_waiting) begin
					op    = op_t'(it.instruction[19:17]);
					d     = it.instruction[16:14];
					s     = it.instruction[13:11];
					t     = it.instruction[10:8];
					imm   = it.instruction[7:0];
					rs    = cpu_regs[s];
					rt    = cpu_regs[t];
					res   = 8'h00;
					wr    = 1'b0;
					taken = 1'b0;
					adv   = 1'b1;
					n_exec++;
					case (op)
						OP_ADD: begin
							res = rs + rt;
							wr  = 1'b1;
						end
						OP_ADDI: begin
							res = rs + imm;
							wr  = 1'b1;
						end
						OP_MUL: begin
							res = rs[7:4] * rs[3:0];
							wr  = 1'b1;
						end
						OP_INV: begin
							res = ~rs;
							wr  = 1'b1;
						end
						OP_BRANCH: begin
							// undefined subcodes fall through as no-ops
							case (d)
								BR_EQ:   taken = (rs == rt);
								BR_NE:   taken = (rs != rt);
								BR_LT:   taken = ($signed(rs) < $signed(rt));
								default: taken = 1'b0;
							endcase
						end
						OP_LOAD: begin
							r.mem_valid   = 1'b1;
							r.mem_address = rt;
							cpu_waiting   = 1'b1;
							cpu_pend_load = 1'b1;
							cpu_pend_dest = d;
							adv           = 1'b0;
							n_mem++;
						end
						OP_STORE: begin
							r.mem_valid    = 1'b1;
							r.mem_is_store = 1'b1;
							r.mem_address  = rt;
							r.store_data   = rs;
							cpu_waiting    = 1'b1;
							cpu_pend_load  = 1'b0;
							adv            = 1'b0;
							n_mem++;
						end
						default: cpu_halted = 1'b1;
					endcase
					if (wr) begin
						cpu_regs[d]     = res;
						r.reg_written   = 1'b1;
						r.written_index = d;
						r.written_value = res;
					end
					if (taken) begin
						cpu_pc = imm;
						n_taken++;
					end else if (adv) begin
						cpu_pc = cpu_pc + 8'd1;
					end
				end
			end
			KIND_DONE: begin
				if (cpu_waiting) begin
					if (cpu_pend_load) begin
						cpu_regs[cpu_pend_dest] = it.load_data;
						r.reg_written   = 1'b1;
						r.written_index = cpu_pend_dest;
						r.written_value = it.load_data;
					end
					cpu_waiting   = 1'b0;
					cpu_pend_load = 1'b0;
					cpu_pc        = cpu_pc + 8'd1;
				end
			end
			KIND_REGWR: begin
				if (it.reg_index < TCE_NUM_REGS) begin
					cpu_regs[it.reg_index[2:0]] = it.reg_value;
					r.reg_written   = 1'b1;
					r.written_index = it.reg_index[2:0];
					r.written_value = it.reg_value;
					n_reg_writes++;
				end else if (it.reg_index == TCE_PC_INDEX) begin
					// PC write also releases halt and drops any outstanding access
					cpu_pc        = it.reg_value;
					cpu_halted    = 1'b0;
					cpu_waiting   = 1'b0;
					cpu_pend_load = 1'b0;
					n_reg_writes++;
				end
			end
			default: ;
		endcase
		r.pc      = cpu_pc;
		r.halted  = cpu_halted;
		r.waiting = cpu_waiting;
		return r;
	endfunction

	// Item builders: fields that the kind does not use carry random noise
	function automatic cpu_item_t mk_insn(op_t op, logic [2:0] d, logic [2:0] s,
	                                      logic [2:0] t, logic [7:0] imm);
		cpu_item_t it;
		it = {KIND_INSN, 8'($urandom), 4'($urandom), 8'($urandom), 20'h0};
		it.instruction = {op, d, s, t, imm};
		return it;
	endfunction

	function automatic cpu_item_t mk_done(logic [7:0] data);
		cpu_item_t it;
		it = {KIND_DONE, 8'($urandom), 4'($urandom), data, 20'($urandom)};
		return it;
	endfunction

	function automatic cpu_item_t mk_regwr(logic [3:0] idx, logic [7:0] val);
		cpu_item_t it;
		it = {KIND_REGWR, val, idx, 8'($urandom), 20'($urandom)};
		return it;
	endfunction

	function automatic logic [7:0] pick_value();
		logic [7:0] corners [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
		if ($urandom_range(0, 2) == 0)
			return corners[$urandom_range(0, 5)];
		return 8'($urandom);
	endfunction

	// Queue an item and track whether it does anything
	function automatic void push_item(cpu_item_t it);
		op_t op;
		op = op_t'(it.instruction[19:17]);
		case (it.kind)
			KIND_INSN: begin
				if (!gen_waiting && !gen_halted) begin
					gen_useful++;
					if (op == OP_LOAD || op == OP_STORE)
						gen_waiting = 1'b1;
					else if (op == OP_HALT)
						gen_halted = 1'b1;
				end
			end
			KIND_DONE: begin
				if (gen_waiting) begin
					gen_useful++;
					gen_waiting = 1'b0;
				end
			end
			KIND_REGWR: begin
				if (it.reg_index <= TCE_PC_INDEX)
					gen_useful++;
				if (it.reg_index == TCE_PC_INDEX) begin
					gen_waiting = 1'b0;
					gen_halted  = 1'b0;
				end
			end
			default: ;
		endcase
		item_q.push_back(it);
	endfunction

	function automatic cpu_item_t random_insn();
		op_t op;
		op = op_t'($urandom_range(0, 7));
		if (op == OP_HALT && $urandom_range(0, 3) != 0)
			op = OP_ADDI;
		return mk_insn(op, 3'($urandom), 3'($urandom), 3'($urandom), 8'($urandom));
	endfunction

	function automatic cpu_item_t noise_item();
		cpu_item_t it;
		case ($urandom_range(0, 3))
			0: it = random_insn();
			1: it = mk_done(8'($urandom));
			2: it = mk_regwr(4'($urandom_range(9, 15)), 8'($urandom));
			default: it = {KIND_NONE, 38'($urandom) << 6 | 38'($urandom)};
		endcase
		return it;
	endfunction

	// Stimulus: directed opening, then mostly well-formed random traffic
	initial begin
		int sel;
		// register and arithmetic extremes
		push_item(mk_regwr(4'd1, 8'h7F));
		push_item(mk_regwr(4'd2, 8'h80));
		push_item(mk_regwr(4'd7, 8'hFF));
		push_item(mk_regwr(4'd0, 8'h00));
		push_item(mk_insn(OP_ADD,  3'd3, 3'd1, 3'd2, 8'h00));
		push_item(mk_insn(OP_ADDI, 3'd4, 3'd7, 3'd0, 8'hFF));
		push_item(mk_insn(OP_MUL,  3'd5, 3'd3, 3'd0, 8'h00));
		push_item(mk_insn(OP_INV,  3'd6, 3'd0, 3'd0, 8'h00));
		// branches: each subcode taken, BR_LT also not taken, plus an undefined subcode
		push_item(mk_insn(OP_BRANCH, BR_EQ, 3'd1, 3'd1, 8'h40));
		push_item(mk_insn(OP_BRANCH, BR_NE, 3'd1, 3'd2, 8'hFF));
		push_item(mk_insn(OP_BRANCH, BR_LT, 3'd2, 3'd1, 8'h00));
		push_item(mk_insn(OP_BRANCH, BR_LT, 3'd1, 3'd2, 8'h11));
		push_item(mk_insn(OP_BRANCH, 3'd5, 3'd0, 3'd0, 8'h22));
		// load with an instruction and an ignored register write while it is outstanding
		push_item(mk_insn(OP_LOAD, 3'd3, 3'd0, 3'd7, 8'h00));
		push_item(mk_insn(OP_ADD, 3'd1, 3'd1, 3'd1, 8'h00));
		push_item(mk_regwr(4'd15, 8'hAA));
		push_item(mk_done(8'hA5));
		push_item(mk_done(8'h5A));
		push_item(mk_insn(OP_STORE, 3'd0, 3'd1, 3'd2, 8'h00));
		push_item(mk_done(8'hFF));
		// halt, ignored instruction, release by PC write, PC wrap
		push_item(mk_insn(OP_HALT, 3'd0, 3'd0, 3'd0, 8'h00));
		push_item(mk_insn(OP_ADD, 3'd2, 3'd2, 3'd2, 8'h00));
		push_item(mk_regwr(TCE_PC_INDEX, 8'hFF));
		push_item(mk_insn(OP_INV, 3'd0, 3'd0, 3'd0, 8'h00));
		// PC write drops a pending load; stray completion and kind 3 are ignored
		push_item(mk_insn(OP_LOAD, 3'd6, 3'd0, 3'd2, 8'h00));
		push_item(mk_regwr(TCE_PC_INDEX, 8'h10));
		push_item(mk_done(8'h33));
		push_item({KIND_NONE, 38'h3F_FFFF_FFFF});

		gen_useful = 0;
		while (gen_useful < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (gen_waiting) begin
				if (sel < 85)
					push_item(mk_done(pick_value()));
				else if (sel < 90)
					push_item(mk_regwr(TCE_PC_INDEX, 8'($urandom)));
				else if (sel < 95)
					push_item(mk_regwr(4'($urandom_range(0, 7)), pick_value()));
				else
					push_item(noise_item());
			end else if (gen_halted) begin
				if (sel < 80)
					push_item(mk_regwr(TCE_PC_INDEX, 8'($urandom)));
				else
					push_item(noise_item());
			end else begin
				if (sel < 70)
					push_item(random_insn());
				else if (sel < 85)
					push_item(mk_regwr(4'($urandom_range(0, 7)), pick_value()));
				else if (sel < 90)
					push_item(mk_regwr(TCE_PC_INDEX, 8'($urandom)));
				else
					push_item(noise_item());
			end
		end

		// reset, then wait for the stream to drain
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (item_q.size() != 0 || s_tvalid || status_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Ran %0d transactions: %0d instructions executed, %0d memory requests,",
		         n_accepted, n_exec, n_mem);
		$display("%0d branches taken, %0d register writes, %0d results checked, %0d mismatches",
		         n_taken, n_reg_writes, n_results, mismatches);
		if (mismatches == 0 && status_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Driver: bursts of items with random gaps; predicts on each accepted transaction
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= KIND_INSN;
		end else begin
			if (s_tvalid && s_tready) begin
				status_q.push_back(exec_item(cur_item));
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (item_q.size() != 0) begin
					cur_item = item_q.pop_front();
					s_tdata  <= {cur_item.reg_value, cur_item.reg_index,
					             cur_item.load_data, cur_item.instruction};
					s_tuser  <= cur_item.kind;
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern in phases, plus one long hold-off to back the block up
	int  rx_mode      = 0;
	int  rx_left      = 0;
	int  hold_left    = 0;
	int  rx_seen      = 0;
	int  rx_phase     = 0;
	bit  held_off     = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				rx_seen++;
			if (!held_off && rx_seen >= 200) begin
				held_off  = 1'b1;
				hold_left = 300;
			end
			if (rx_left <= 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(5, 60);
			end
			rx_left--;
			rx_phase++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 0);
					2: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= (rx_phase % 3 != 0);
				endcase
			end
		end
	end

	// Monitor: each accepted result against the oldest prediction
	always @(posedge clk) begin
		status_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = status_t'(m_tdata);
			n_results++;
			if (status_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("[%0t] unexpected result %h with nothing outstanding", $realtime,
					         m_tdata);
			end else begin
				want = status_q.pop_front();
				if (got.pc != want.pc || got.halted != want.halted ||
				    got.waiting != want.waiting || got.mem_valid != want.mem_valid ||
				    got.mem_is_store != want.mem_is_store ||
				    got.mem_address != want.mem_address ||
				    got.store_data != want.store_data ||
				    got.reg_written != want.reg_written ||
				    got.written_index != want.written_index ||
				    got.written_value != want.written_value) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("[%0t] result %0d mismatch", $realtime, n_results);
						$display("  exp pc=%h h=%b w=%b mv=%b st=%b ma=%h sd=%h rw=%b wi=%0d wv=%h",
						         want.pc, want.halted, want.waiting, want.mem_valid,
						         want.mem_is_store, want.mem_address, want.store_data,
						         want.reg_written, want.written_index, want.written_value);
						$display("  got pc=%h h=%b w=%b mv=%b st=%b ma=%h sd=%h rw=%b wi=%0d wv=%h",
						         got.pc, got.halted, got.waiting, got.mem_valid,
						         got.mem_is_store, got.mem_address, got.store_data,
						         got.reg_written, got.written_index, got.written_value);
					end
				end
			end
		end
	end

	// Watchdog
	int cycles = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
			         status_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule
